@@ rtl/core/isotp_pkg.sv @@
// Shared types and constants for the ISO-TP segmenting and reassembly block.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package isotp_pkg;
  localparam int MAX_PAYLOAD_DEFAULT = 4095;

  localparam logic [1:0] CMD_BYTE  = 2'd0;
  localparam logic [1:0] CMD_FRAME = 2'd1;
  localparam logic [1:0] CMD_TICK  = 2'd2;

  localparam logic [1:0] REG_REQ_ID  = 2'd0;
  localparam logic [1:0] REG_RSP_ID  = 2'd1;
  localparam logic [1:0] REG_TIMEOUT = 2'd2;
  localparam logic [1:0] REG_CAP     = 2'd3;

  localparam logic [3:0] OC_OK       = 4'd0;
  localparam logic [3:0] OC_BAD_REQ  = 4'd1;
  localparam logic [3:0] OC_FC_TMO   = 4'd2;
  localparam logic [3:0] OC_NOT_FC   = 4'd3;
  localparam logic [3:0] OC_RSP_TMO  = 4'd4;
  localparam logic [3:0] OC_BAD_SF   = 4'd5;
  localparam logic [3:0] OC_SIZE     = 4'd6;
  localparam logic [3:0] OC_CF_TMO   = 4'd7;
  localparam logic [3:0] OC_NOT_CF   = 4'd8;
  localparam logic [3:0] OC_SEQ      = 4'd9;
  localparam logic [3:0] OC_UNKNOWN  = 4'd10;

  typedef struct packed {
    logic [1:0]  command;
    logic [7:0]  request_byte;
    logic        request_last;
    logic [10:0] rx_frame_id;
    logic [63:0] rx_frame_bytes;
    logic [6:0]  rx_frame_length;
  } in_item_t;

  typedef struct packed {
    logic        send_valid;
    logic [63:0] send_bytes;
    logic        chunk_valid;
    logic [55:0] chunk_bytes;
    logic [2:0]  chunk_count;
    logic        finished;
    logic [3:0]  outcome;
    logic [11:0] response_length;
  } out_item_t;
endpackage
`default_nettype wire

@@ rtl/core/isotp_segment_reassemble.sv @@
// ISO-TP segmenting and reassembly, top level; uses isotp_pkg.
// Results: a result is registered into the output buffer when its request is
//   accepted; a frame from stored request bytes is read from memory, then built.
// Throughput: one request per cycle unless intake is held off: a request whose
//   frame reads the byte memory holds it off, as does a full two-entry buffer.
// Reset (synchronous, rst): registers take their reset values; the byte memory
//   is left undefined, as entries are only read after being written.
`timescale 1ns / 1ps
`default_nettype none
module isotp_segment_reassemble import isotp_pkg::*; #(
  parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEFAULT
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_item_t  in_data,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_item_t      out_data,
  input  wire logic      cfg_write,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);
  localparam logic [11:0] MAXP = 12'(MAX_PAYLOAD);

  // Phases of the transaction, one-hot.
  typedef enum logic [4:0] {
    PH_IDLE = 5'b00001, PH_WAIT_FC = 5'b00010, PH_SEND_CF = 5'b00100,
    PH_WAIT_RESP = 5'b01000, PH_WAIT_CF = 5'b10000
  } phase_t;

  logic [10:0] request_can_id, response_can_id;
  logic [15:0] timeout_ticks;
  logic [11:0] response_capacity;

  always_ff @(posedge clk) begin
    if (rst) begin
      request_can_id <= 11'd2016;
      response_can_id <= 11'd2024;
      timeout_ticks <= 16'd1000;
      response_capacity <= 12'd4095;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_REQ_ID:  request_can_id <= cfg_data[10:0];
        REG_RSP_ID:  response_can_id <= cfg_data[10:0];
        REG_TIMEOUT: timeout_ticks <= cfg_data;
        REG_CAP:     response_capacity <= cfg_data[11:0];
        default: ;
      endcase
    end
  end

  // The identifier of transmitted frames is carried outside the result.
  logic unused_id;
  assign unused_id = ^request_can_id;

  // The request bytes sit in a memory eight bytes wide, one lane per byte
  // position modulo eight, so that any run of up to seven consecutive bytes
  // is covered by one row and the next. Two rows are read per access.
  localparam int ROWS = (MAX_PAYLOAD + 7) / 8;
  localparam int RW = (ROWS > 1) ? $clog2(ROWS) : 1;
  logic [7:0] mem [8][ROWS];
  logic [7:0] rd_a [8];
  logic [7:0] rd_b [8];
  logic [RW-1:0] rd_row;
  logic          rd_en;
  logic [RW-1:0] wr_row;
  logic [2:0]    wr_lane;
  logic          wr_en;
  logic [7:0]    wr_byte;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_lane][wr_row] <= wr_byte;
  end
  // Row b is the row after row a; at the last row, row b repeats row a.
  logic [RW-1:0] rd_row_b;
  assign rd_row_b = (32'(rd_row) + 1 < ROWS) ? rd_row + RW'(1) : rd_row;
  always_ff @(posedge clk) begin
    if (rd_en) begin
      for (int l = 0; l < 8; l++) begin
        rd_a[l] <= mem[l][rd_row];
        rd_b[l] <= mem[l][rd_row_b];
      end
    end
  end

  phase_t      phase, phase_next;
  logic [11:0] request_count, request_count_next;
  logic        req_overflow, req_overflow_next;
  logic [11:0] send_offset, send_offset_next;
  logic [3:0]  send_sequence, send_sequence_next;
  logic [11:0] receive_total, receive_total_next;
  logic [11:0] receive_count, receive_count_next;
  logic [3:0]  expected_sequence, expected_sequence_next;
  logic [16:0] wait_ticks, wait_ticks_next;

  // Build step of a frame from memory: its header and layout are held
  // here while the two rows are read.
  logic        pend, pend_next;
  logic [2:0]  pend_off, pend_off_next;
  logic [3:0]  pend_chunk, pend_chunk_next;
  logic [7:0]  pend_hdr0, pend_hdr0_next, pend_hdr1, pend_hdr1_next;
  logic        pend_is_ff, pend_is_ff_next;
  // The last byte of a single-frame request is written in the same cycle as
  // row zero is read, so it is carried past the memory and patched in.
  logic        fwd_en, fwd_en_next;
  logic [2:0]  fwd_lane, fwd_lane_next;
  logic [7:0]  fwd_byte, fwd_byte_next;

  out_item_t res_next;
  logic      res_load;

  // Two-entry output buffer: head is offered, tail catches a result that
  // arrives while the head is stalled.
  out_item_t head, tail;
  logic      head_v, tail_v;
  logic      pop;

  logic accept;
  // Intake stops while a memory frame is being built or the buffer is full.
  // A request accepted now always finds room for its result, which lands
  // either at this edge or, for a memory frame, once its frame is built.
  assign in_ready = !pend && !tail_v;
  assign accept = in_valid && in_ready;

  // Frame bytes with length masking.
  logic [7:0] b [8];
  logic [3:0] len;
  always_comb begin
    len = (in_data.rx_frame_length > 7'd8) ? 4'd8 : in_data.rx_frame_length[3:0];
    for (int k = 0; k < 8; k++)
      b[k] = (4'(k) < len) ? in_data.rx_frame_bytes[63-8*k -: 8] : 8'h00;
  end

  function automatic logic [55:0] pack_chunk(input logic [7:0] v [8], input int first,
                                             input logic [3:0] n);
    logic [55:0] r;
    r = '0;
    for (int i = 0; i < 7; i++)
      if (4'(i) < n) r[55-8*i -: 8] = v[3'(first + i)];
    return r;
  endfunction

  always_comb begin
    logic [11:0] chunk12, total;
    logic [3:0]  n;
    logic        do_tick;
    logic [7:0]  w [16];
    logic [63:0] f;
    out_item_t   fin;
    phase_next = phase;
    request_count_next = request_count;
    req_overflow_next = req_overflow;
    send_offset_next = send_offset;
    send_sequence_next = send_sequence;
    receive_total_next = receive_total;
    receive_count_next = receive_count;
    expected_sequence_next = expected_sequence;
    wait_ticks_next = wait_ticks;
    pend_next = 1'b0;
    pend_off_next = pend_off;
    pend_chunk_next = pend_chunk;
    pend_hdr0_next = pend_hdr0;
    pend_hdr1_next = pend_hdr1;
    pend_is_ff_next = pend_is_ff;
    fwd_en_next = 1'b0;
    fwd_lane_next = fwd_lane;
    fwd_byte_next = fwd_byte;
    res_next = '0;
    res_load = 1'b0;
    wr_en = 1'b0;
    wr_row = request_count[3 +: RW];
    wr_lane = request_count[2:0];
    wr_byte = in_data.request_byte;
    rd_en = 1'b0;
    rd_row = '0;
    chunk12 = '0;
    total = '0;
    n = '0;
    do_tick = 1'b0;
    fin = '0;
    fin.finished = 1'b1;
    for (int l = 0; l < 8; l++) begin
      w[l] = rd_a[l];
      w[l+8] = rd_b[l];
    end
    if (fwd_en) w[{1'b0, fwd_lane}] = fwd_byte;
    f = '0;

    if (pend) begin
      // Assemble the frame from the two rows read in the previous cycle.
      f[63:56] = pend_hdr0;
      if (pend_is_ff) begin
        f[55:48] = pend_hdr1;
        for (int i = 0; i < 6; i++) f[47-8*i -: 8] = w[i];
      end else begin
        for (int i = 0; i < 7; i++)
          if (4'(i) < pend_chunk) f[55-8*i -: 8] = w[{1'b0, pend_off} + 4'(i)];
      end
      res_load = 1'b1;
      res_next.send_valid = 1'b1;
      res_next.send_bytes = f;
    end else if (accept) begin
      res_load = 1'b1;
      unique case (in_data.command)
        CMD_BYTE: begin
          if (phase == PH_IDLE) begin
            if (request_count < MAXP) begin
              wr_en = 1'b1;
              request_count_next = request_count + 12'd1;
            end else begin
              req_overflow_next = 1'b1;
            end
            if (in_data.request_last) begin
              if (req_overflow_next || request_count_next == 12'd0) begin
                res_next = fin;
                res_next.outcome = OC_BAD_REQ;
                phase_next = PH_IDLE;
                request_count_next = '0;
                req_overflow_next = 1'b0;
              end else begin
                // Row zero is read now and the frame is built next cycle.
                res_load = 1'b0;
                pend_next = 1'b1;
                rd_en = 1'b1;
                rd_row = '0;
                pend_off_next = '0;
                wait_ticks_next = '0;
                if (request_count_next <= 12'd7) begin
                  pend_is_ff_next = 1'b0;
                  pend_hdr0_next = {4'h0, request_count_next[3:0]};
                  pend_chunk_next = request_count_next[3:0];
                  fwd_en_next = 1'b1;
                  fwd_lane_next = request_count[2:0];
                  fwd_byte_next = in_data.request_byte;
                  phase_next = PH_WAIT_RESP;
                end else begin
                  pend_is_ff_next = 1'b1;
                  pend_hdr0_next = {4'h1, request_count_next[11:8]};
                  pend_hdr1_next = request_count_next[7:0];
                  send_offset_next = 12'd6;
                  send_sequence_next = 4'd1;
                  phase_next = PH_WAIT_FC;
                end
              end
            end
          end
        end
        CMD_FRAME: begin
          if (in_data.rx_frame_id == response_can_id && len != 4'd0) begin
            if (phase == PH_WAIT_FC) begin
              if (b[0][7:4] != 4'h3) begin
                res_next = fin;
                res_next.outcome = OC_NOT_FC;
                phase_next = PH_IDLE;
                request_count_next = '0;
                req_overflow_next = 1'b0;
              end else begin
                do_tick = 1'b1;
              end
            end else if (phase == PH_WAIT_RESP) begin
              if (b[0][7:4] == 4'h0) begin
                n = {1'b0, b[0][2:0]};
                res_next = fin;
                phase_next = PH_IDLE;
                request_count_next = '0;
                req_overflow_next = 1'b0;
                if (b[0][3] || ({1'b0, b[0][3:0]} + 5'd1 > {1'b0, len})) begin
                  res_next.outcome = OC_BAD_SF;
                end else if (12'(b[0][3:0]) > response_capacity) begin
                  res_next.outcome = OC_SIZE;
                end else begin
                  res_next.chunk_valid = (n != 4'd0);
                  res_next.chunk_bytes = pack_chunk(b, 1, n);
                  res_next.chunk_count = n[2:0];
                  res_next.response_length = 12'(n);
                end
              end else if (b[0][7:4] == 4'h1) begin
                total = {b[0][3:0], b[1]};
                if (total > response_capacity || total == 12'd0) begin
                  res_next = fin;
                  res_next.outcome = OC_SIZE;
                  phase_next = PH_IDLE;
                  request_count_next = '0;
                  req_overflow_next = 1'b0;
                end else begin
                  n = (total < 12'd6) ? total[3:0] : 4'd6;
                  res_next.chunk_valid = 1'b1;
                  res_next.chunk_bytes = pack_chunk(b, 2, n);
                  res_next.chunk_count = n[2:0];
                  res_next.send_valid = 1'b1;
                  res_next.send_bytes = {8'h30, 56'h0};
                  receive_total_next = total;
                  receive_count_next = 12'(n);
                  expected_sequence_next = 4'd1;
                  wait_ticks_next = '0;
                  if (12'(n) >= total) begin
                    res_next.finished = 1'b1;
                    res_next.response_length = total;
                    phase_next = PH_IDLE;
                    request_count_next = '0;
                    req_overflow_next = 1'b0;
                  end else begin
                    phase_next = PH_WAIT_CF;
                  end
                end
              end else begin
                res_next = fin;
                res_next.outcome = OC_UNKNOWN;
                phase_next = PH_IDLE;
                request_count_next = '0;
                req_overflow_next = 1'b0;
              end
            end else if (phase == PH_WAIT_CF) begin
              if (b[0][7:4] != 4'h2) begin
                res_next = fin;
                res_next.outcome = OC_NOT_CF;
                phase_next = PH_IDLE;
                request_count_next = '0;
                req_overflow_next = 1'b0;
              end else if (b[0][3:0] != expected_sequence) begin
                res_next = fin;
                res_next.outcome = OC_SEQ;
                phase_next = PH_IDLE;
                request_count_next = '0;
                req_overflow_next = 1'b0;
              end else begin
                chunk12 = receive_total - receive_count;
                n = (chunk12 > 12'd7) ? 4'd7 : chunk12[3:0];
                res_next.chunk_valid = (n != 4'd0);
                res_next.chunk_bytes = pack_chunk(b, 1, n);
                res_next.chunk_count = n[2:0];
                receive_count_next = receive_count + 12'(n);
                expected_sequence_next = expected_sequence + 4'd1;
                wait_ticks_next = '0;
                if (receive_count_next >= receive_total) begin
                  res_next.finished = 1'b1;
                  res_next.response_length = receive_total;
                  phase_next = PH_IDLE;
                  request_count_next = '0;
                  req_overflow_next = 1'b0;
                end
              end
            end
          end
        end
        CMD_TICK: begin
          if (phase == PH_SEND_CF) begin
            do_tick = 1'b1;
          end else if (phase != PH_IDLE) begin
            wait_ticks_next = wait_ticks + 17'd1;
            if (wait_ticks_next > 17'(timeout_ticks)) begin
              res_next = fin;
              res_next.outcome = (phase == PH_WAIT_FC) ? OC_FC_TMO :
                                 (phase == PH_WAIT_RESP) ? OC_RSP_TMO : OC_CF_TMO;
              phase_next = PH_IDLE;
              request_count_next = '0;
              req_overflow_next = 1'b0;
            end
          end
        end
        default: ;
      endcase
      if (do_tick) begin
        // Send the next consecutive frame: read its rows now, build next cycle.
        chunk12 = request_count - send_offset;
        n = (chunk12 > 12'd7) ? 4'd7 : chunk12[3:0];
        res_load = 1'b0;
        pend_next = 1'b1;
        pend_is_ff_next = 1'b0;
        pend_hdr0_next = {4'h2, send_sequence};
        pend_chunk_next = n;
        pend_off_next = send_offset[2:0];
        rd_en = 1'b1;
        rd_row = send_offset[3 +: RW];
        send_offset_next = send_offset + 12'(n);
        send_sequence_next = send_sequence + 4'd1;
        phase_next = PH_SEND_CF;
        if (send_offset_next >= request_count) begin
          phase_next = PH_WAIT_RESP;
          wait_ticks_next = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      request_count <= '0;
      req_overflow <= 1'b0;
      send_offset <= '0;
      send_sequence <= 4'd1;
      receive_total <= '0;
      receive_count <= '0;
      expected_sequence <= 4'd1;
      wait_ticks <= '0;
      pend <= 1'b0;
      fwd_en <= 1'b0;
    end else begin
      phase <= phase_next;
      request_count <= request_count_next;
      req_overflow <= req_overflow_next;
      send_offset <= send_offset_next;
      send_sequence <= send_sequence_next;
      receive_total <= receive_total_next;
      receive_count <= receive_count_next;
      expected_sequence <= expected_sequence_next;
      wait_ticks <= wait_ticks_next;
      pend <= pend_next;
      fwd_en <= fwd_en_next;
    end
    pend_off <= pend_off_next;
    pend_chunk <= pend_chunk_next;
    pend_hdr0 <= pend_hdr0_next;
    pend_hdr1 <= pend_hdr1_next;
    pend_is_ff <= pend_is_ff_next;
    fwd_lane <= fwd_lane_next;
    fwd_byte <= fwd_byte_next;
  end

  // Output buffer: a new result goes to the head when it is free, otherwise
  // to the tail; the tail moves up when the head is taken.
  assign pop = head_v && out_ready;
  always_ff @(posedge clk) begin
    if (rst) begin
      head_v <= 1'b0;
      tail_v <= 1'b0;
    end else if (pop) begin
      if (tail_v) begin
        head <= tail;
        tail_v <= res_load;
        if (res_load) tail <= res_next;
      end else begin
        head_v <= res_load;
        if (res_load) head <= res_next;
      end
    end else if (res_load) begin
      if (head_v) begin
        tail <= res_next;
        tail_v <= 1'b1;
      end else begin
        head <= res_next;
        head_v <= 1'b1;
      end
    end
  end
  assign out_valid = head_v;
  assign out_data = head;
endmodule
`default_nettype wire
